@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

@@ hw/rtl/macd_pkg.sv @@
package macd_pkg;

   // Default sample and fraction widths
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // Coefficients are Q16, unsigned, one extra bit to hold 1.0
   localparam int ALPHA_BITS = 16;
   localparam int ALPHA_W    = ALPHA_BITS + 1;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_BITS;

   localparam logic [ALPHA_W-1:0] SHORT_ALPHA_RST  = ALPHA_W'(10082);
   localparam logic [ALPHA_W-1:0] LONG_ALPHA_RST   = ALPHA_W'(4855);
   localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = ALPHA_W'(13107);

   // Register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_ALPHA  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_ALPHA   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNAL_ALPHA = CSR_IDX_W'(2);

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Head-of-queue status seen by the back end
   typedef struct packed {
      logic valid;
      logic seed;
   } q_status_type;

   // Coefficients above one act as one
   function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
      clamp_alpha = (a > ALPHA_ONE) ? ALPHA_ONE : a;
   endfunction

endpackage

@@ hw/rtl/macd_front.sv @@
module macd_front #(
   parameter int SAMPLE_BITS = macd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic signed [SAMPLE_BITS-1:0] req_price,
   input  logic                          req_series_start,
   output macd_pkg::q_status_type        q_stat,
   output logic signed [SAMPLE_BITS-1:0] q_price,
   input  logic                          q_pop
);

   localparam int DEPTH = macd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic signed [SAMPLE_BITS-1:0] price_mem_ff [DEPTH];
   logic                          seed_mem_ff  [DEPTH];
   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          seen_ff, seen_in;
   logic                          push;
   logic                          seed;

   assign req_tready = (count_ff != CNT_W'(DEPTH));
   assign push       = req_tvalid && req_tready;

   // Classify: the first beat after reset or a flagged beat seeds the averages
   assign seed    = req_series_start || !seen_ff;
   assign seen_in = seen_ff || push;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         seen_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
      end
   end

   // Hold queued beats
   always_ff @(posedge clock) begin
      if (push) begin
         price_mem_ff[wr_ptr_ff] <= req_price;
         seed_mem_ff[wr_ptr_ff]  <= seed;
      end
   end

   assign q_stat.valid = (count_ff != '0);
   assign q_stat.seed  = seed_mem_ff[rd_ptr_ff];
   assign q_price      = price_mem_ff[rd_ptr_ff];

endmodule

@@ hw/rtl/macd_back.sv @@
`include "assert_macros.svh"

module macd_back #(
   parameter int SAMPLE_BITS = macd_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = macd_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [macd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [macd_pkg::ALPHA_W-1:0]          csr_wdata,
   input  macd_pkg::q_status_type                q_stat,
   input  logic signed [SAMPLE_BITS-1:0]         q_price,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic signed [SAMPLE_BITS:0]           rsp_macd,
   output logic signed [SAMPLE_BITS:0]           rsp_signal,
   output logic signed [SAMPLE_BITS+1:0]         rsp_hist
);

   localparam int ALPHA_W    = macd_pkg::ALPHA_W;
   localparam int ALPHA_BITS = macd_pkg::ALPHA_BITS;
   localparam int AVG_W  = SAMPLE_BITS + FRAC_BITS;  // short and long averages
   localparam int SIG_W  = AVG_W + 1;                // macd and signal average
   localparam int DL_W   = AVG_W + 1;                // short/long step difference
   localparam int DS_W   = SIG_W + 1;                // signal step difference
   localparam int A_W    = ALPHA_W + 1;              // coefficient as signed
   localparam int PL_W   = DL_W + A_W;
   localparam int PS_W   = DS_W + A_W;
   localparam int PLX_W  = PL_W + 1;
   localparam int PSX_W  = PS_W + 1;
   localparam int SGX_W  = SIG_W + 1;
   localparam int OUT_W  = SAMPLE_BITS + 1;
   localparam int HIST_W = SAMPLE_BITS + 2;

   localparam logic signed [PLX_W-1:0] HALF_PL = PLX_W'(1) <<< (ALPHA_BITS - 1);
   localparam logic signed [PSX_W-1:0] HALF_PS = PSX_W'(1) <<< (ALPHA_BITS - 1);
   localparam logic signed [SGX_W-1:0] HALF_FR = SGX_W'(1) <<< (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_MACD,
      ST_SMUL,
      ST_SUPD,
      ST_RND,
      ST_OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic [ALPHA_W-1:0]         short_alpha_ff, short_alpha_in;
   logic [ALPHA_W-1:0]         long_alpha_ff, long_alpha_in;
   logic [ALPHA_W-1:0]         signal_alpha_ff, signal_alpha_in;
   logic signed [AVG_W-1:0]    short_ff, short_in;
   logic signed [AVG_W-1:0]    long_ff, long_in;
   logic signed [SIG_W-1:0]    sig_ff, sig_in;
   logic signed [SIG_W-1:0]    macd_ff, macd_in;
   logic signed [DL_W-1:0]     d_s_ff, d_s_in;
   logic signed [DL_W-1:0]     d_l_ff, d_l_in;
   logic signed [DS_W-1:0]     d_g_ff, d_g_in;
   logic signed [PL_W-1:0]     p_s_ff, p_s_in;
   logic signed [PL_W-1:0]     p_l_ff, p_l_in;
   logic signed [PS_W-1:0]     p_g_ff, p_g_in;
   logic signed [OUT_W-1:0]    rm_ff, rm_in;
   logic signed [OUT_W-1:0]    rs_ff, rs_in;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [OUT_W-1:0]    rsp_macd_ff, rsp_macd_in;
   logic signed [OUT_W-1:0]    rsp_signal_ff, rsp_signal_in;
   logic signed [HIST_W-1:0]   rsp_hist_ff, rsp_hist_in;

   logic signed [AVG_W-1:0]    xs;
   logic signed [A_W-1:0]      a_s, a_l, a_g;
   logic signed [PLX_W-1:0]    q_s, q_l, sum_s, sum_l;
   logic signed [PSX_W-1:0]    q_g, sum_g;
   logic signed [SIG_W-1:0]    macd_new;
   logic signed [SGX_W-1:0]    rnd_m, rnd_g;
   logic                       out_load;

   // Sample scaled up by the fraction bits
   assign xs = {q_price, {FRAC_BITS{1'b0}}};

   // Clamped coefficients as signed multiplier operands
   assign a_s = $signed({1'b0, macd_pkg::clamp_alpha(short_alpha_ff)});
   assign a_l = $signed({1'b0, macd_pkg::clamp_alpha(long_alpha_ff)});
   assign a_g = $signed({1'b0, macd_pkg::clamp_alpha(signal_alpha_ff)});

   // Round the scaled steps half away from zero
   always_comb begin
      q_s = ({p_s_ff[PL_W-1], p_s_ff} + (p_s_ff[PL_W-1] ? HALF_PL - PLX_W'(1) : HALF_PL))
            >>> ALPHA_BITS;
      q_l = ({p_l_ff[PL_W-1], p_l_ff} + (p_l_ff[PL_W-1] ? HALF_PL - PLX_W'(1) : HALF_PL))
            >>> ALPHA_BITS;
      q_g = ({p_g_ff[PS_W-1], p_g_ff} + (p_g_ff[PS_W-1] ? HALF_PS - PSX_W'(1) : HALF_PS))
            >>> ALPHA_BITS;
      sum_s = q_s + PLX_W'(short_ff);
      sum_l = q_l + PLX_W'(long_ff);
      sum_g = q_g + PSX_W'(sig_ff);
   end

   // Round macd and signal to whole thousandths
   always_comb begin
      rnd_m = ({macd_ff[SIG_W-1], macd_ff}
               + (macd_ff[SIG_W-1] ? HALF_FR - SGX_W'(1) : HALF_FR)) >>> FRAC_BITS;
      rnd_g = ({sig_ff[SIG_W-1], sig_ff}
               + (sig_ff[SIG_W-1] ? HALF_FR - SGX_W'(1) : HALF_FR)) >>> FRAC_BITS;
   end

   assign macd_new = SIG_W'(short_ff) - SIG_W'(long_ff);
   assign q_pop    = (state_ff == ST_IDLE) && q_stat.valid;
   assign out_load = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);

   // Sequence one beat through the three averages
   always_comb begin
      state_in        = state_ff;
      short_alpha_in  = short_alpha_ff;
      long_alpha_in   = long_alpha_ff;
      signal_alpha_in = signal_alpha_ff;
      short_in        = short_ff;
      long_in         = long_ff;
      sig_in          = sig_ff;
      macd_in         = macd_ff;
      d_s_in          = d_s_ff;
      d_l_in          = d_l_ff;
      d_g_in          = d_g_ff;
      p_s_in          = p_s_ff;
      p_l_in          = p_l_ff;
      p_g_in          = p_g_ff;
      rm_in           = rm_ff;
      rs_in           = rs_ff;
      rsp_macd_in     = rsp_macd_ff;
      rsp_signal_in   = rsp_signal_ff;
      rsp_hist_in     = rsp_hist_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;

      if (csr_we) begin
         case (csr_index)
            macd_pkg::CSR_SHORT_ALPHA:  short_alpha_in  = csr_wdata;
            macd_pkg::CSR_LONG_ALPHA:   long_alpha_in   = csr_wdata;
            macd_pkg::CSR_SIGNAL_ALPHA: signal_alpha_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (q_stat.seed) begin
                  short_in = xs;
                  long_in  = xs;
                  macd_in  = '0;
                  sig_in   = '0;
                  state_in = ST_RND;
               end else begin
                  d_s_in   = DL_W'(xs) - DL_W'(short_ff);
                  d_l_in   = DL_W'(xs) - DL_W'(long_ff);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            p_s_in   = d_s_ff * a_s;
            p_l_in   = d_l_ff * a_l;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            short_in = sum_s[AVG_W-1:0];
            long_in  = sum_l[AVG_W-1:0];
            state_in = ST_MACD;
         end
         ST_MACD: begin
            macd_in  = macd_new;
            d_g_in   = DS_W'(macd_new) - DS_W'(sig_ff);
            state_in = ST_SMUL;
         end
         ST_SMUL: begin
            p_g_in   = d_g_ff * a_g;
            state_in = ST_SUPD;
         end
         ST_SUPD: begin
            sig_in   = sum_g[SIG_W-1:0];
            state_in = ST_RND;
         end
         ST_RND: begin
            rm_in    = rnd_m[OUT_W-1:0];
            rs_in    = rnd_g[OUT_W-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_macd_in   = rm_ff;
               rsp_signal_in = rs_ff;
               rsp_hist_in   = HIST_W'(rm_ff) - HIST_W'(rs_ff);
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_tvalid_ff   <= 1'b0;
         short_alpha_ff  <= macd_pkg::SHORT_ALPHA_RST;
         long_alpha_ff   <= macd_pkg::LONG_ALPHA_RST;
         signal_alpha_ff <= macd_pkg::SIGNAL_ALPHA_RST;
      end else begin
         state_ff        <= state_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
         short_alpha_ff  <= short_alpha_in;
         long_alpha_ff   <= long_alpha_in;
         signal_alpha_ff <= signal_alpha_in;
      end
      short_ff      <= short_in;
      long_ff       <= long_in;
      sig_ff        <= sig_in;
      macd_ff       <= macd_in;
      d_s_ff        <= d_s_in;
      d_l_ff        <= d_l_in;
      d_g_ff        <= d_g_in;
      p_s_ff        <= p_s_in;
      p_l_ff        <= p_l_in;
      p_g_ff        <= p_g_in;
      rm_ff         <= rm_in;
      rs_ff         <= rs_in;
      rsp_macd_ff   <= rsp_macd_in;
      rsp_signal_ff <= rsp_signal_in;
      rsp_hist_ff   <= rsp_hist_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_macd   = rsp_macd_ff;
   assign rsp_signal = rsp_signal_ff;
   assign rsp_hist   = rsp_hist_ff;

   // A seed beat skips the averaging and rounds a zero macd and signal
   `ASSERT_NEXT(a_seed_path, clock, reset, q_pop && q_stat.seed,
                state_ff == ST_RND && macd_ff == '0 && sig_ff == '0)
   // An ordinary beat starts the multiply chain
   `ASSERT_NEXT(a_update_path, clock, reset, q_pop && !q_stat.seed, state_ff == ST_MUL)
   // A result appears only out of the output state
   `ASSERT_IMPLIES(a_valid_source, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff) == ST_OUT)

endmodule

@@ hw/rtl/macd_indicator_filter.sv @@
// MACD filter over a stream of signed price samples in thousandths. Each req beat carries one
// sample and a series-start flag; each rsp beat carries the rounded MACD, the rounded signal
// line and their difference. A beat whose flag is set, or the first beat after reset, reseeds
// all averages and returns zeros. An ordinary beat runs through the back-end states IDLE, MUL,
// UPD, MACD, SMUL, SUPD, RND and OUT: the short/long update and then the signal update, each a
// subtract, a registered multiply and a round-and-add; a seed beat goes from IDLE to RND and
// OUT. A two-beat queue sits between the input side and the back end, and the result register
// lets the next beat proceed while a result waits. Coefficients are Q16 (65536 = 1.0, larger
// values act as 1.0) and should be written while no beat is in flight.
module macd_indicator_filter #(
   parameter int SAMPLE_BITS = macd_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = macd_pkg::FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // req_tdata: price [SAMPLE_BITS-1:0]
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  req_tdata,
   // req_tuser: series_start
   input  logic                                      req_tuser,
   // rsp_tdata: macd_value, signal_value, histogram_value, zero fill
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((3 * SAMPLE_BITS + 11) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                      csr_we,
   input  logic [macd_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [macd_pkg::ALPHA_W-1:0]              csr_wdata
);

   localparam int RSP_W = ((3 * SAMPLE_BITS + 11) / 8) * 8;

   macd_pkg::q_status_type        q_stat;
   logic signed [SAMPLE_BITS-1:0] q_price;
   logic                          q_pop;
   logic signed [SAMPLE_BITS:0]   rsp_macd;
   logic signed [SAMPLE_BITS:0]   rsp_signal;
   logic signed [SAMPLE_BITS+1:0] rsp_hist;

   macd_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_price       ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .req_series_start(req_tuser),
      .q_stat          (q_stat),
      .q_price         (q_price),
      .q_pop           (q_pop)
   );

   macd_back #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .q_price   (q_price),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_macd  (rsp_macd),
      .rsp_signal(rsp_signal),
      .rsp_hist  (rsp_hist)
   );

   // Pack result fields from the lowest bit up, zero fill on top
   assign rsp_tdata = RSP_W'({rsp_hist, rsp_signal, rsp_macd});

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int PRICE_W   = macd_pkg::SAMPLE_BITS_DEF;
   localparam int FRAC_W    = macd_pkg::FRAC_BITS_DEF;
   localparam int REQ_W     = ((PRICE_W + 7) / 8) * 8;
   localparam int RSP_W     = ((3 * PRICE_W + 11) / 8) * 8;
   localparam int DRAIN_WAIT  = 40;
   localparam int CYCLE_LIMIT = 400000;

   // Index with no register behind it
   localparam logic [macd_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = macd_pkg::CSR_IDX_W'(3);

   localparam logic [PRICE_W-1:0] PRICE_MAX = {1'b0, {(PRICE_W - 1){1'b1}}};
   localparam logic [PRICE_W-1:0] PRICE_MIN = {1'b1, {(PRICE_W - 1){1'b0}}};
   localparam logic [macd_pkg::ALPHA_W-1:0] ALPHA_TOP = {macd_pkg::ALPHA_W{1'b1}};

   typedef struct packed {
      logic [32:0] macd_value;
      logic [32:0] signal_value;
      logic [33:0] histogram_value;
   } macd_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [REQ_W-1:0]               req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [RSP_W-1:0]               rsp_tdata;
   logic                           csr_we = 1'b0;
   logic [macd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [macd_pkg::ALPHA_W-1:0]   csr_wdata = '0;

   // Mirror of the filter state and coefficients
   logic [63:0]                  short_ema;
   logic [63:0]                  long_ema;
   logic [63:0]                  signal_ema;
   logic                         series_open;
   logic [macd_pkg::ALPHA_W-1:0] short_alpha_cfg;
   logic [macd_pkg::ALPHA_W-1:0] long_alpha_cfg;
   logic [macd_pkg::ALPHA_W-1:0] signal_alpha_cfg;

   macd_result_type expected_macd_q[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   bit              sender_gaps_on = 1'b1;
   bit              receiver_stalls_on = 1'b1;
   int              rsp_hold_cycles = 0;

   macd_indicator_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // One exponential average update: avg += alpha * (target - avg), rounded half away
   function automatic logic [63:0] ema_advance(input logic [63:0] avg,
                                              input logic [63:0] target,
                                              input logic [macd_pkg::ALPHA_W-1:0] alpha);
      logic [63:0] diff;
      logic [63:0] mag;
      logic [63:0] coef;
      logic [63:0] delta;
      logic        neg;
      diff  = target - avg;
      neg   = diff[63];
      mag   = neg ? -diff : diff;
      coef  = (alpha > macd_pkg::ALPHA_ONE) ? 64'(macd_pkg::ALPHA_ONE) : 64'(alpha);
      delta = (mag >> macd_pkg::ALPHA_BITS) * coef
            + (((mag & 64'hFFFF) * coef + (64'd1 << (macd_pkg::ALPHA_BITS - 1)))
               >> macd_pkg::ALPHA_BITS);
      return avg + (neg ? -delta : delta);
   endfunction

   // Drop the fraction bits, half away from zero
   function automatic logic [63:0] to_thousandths(input logic [63:0] v);
      logic [63:0] half;
      half = 64'd1 << (FRAC_W - 1);
      if (v[63])
         return -((-v + half) >> FRAC_W);
      return (v + half) >> FRAC_W;
   endfunction

   function automatic macd_result_type macd_predict(input logic [PRICE_W-1:0] price,
                                                    input logic start);
      logic [63:0]     scaled;
      logic [63:0]     macd_fx;
      logic [63:0]     macd_r;
      logic [63:0]     signal_r;
      logic [63:0]     hist_r;
      macd_result_type res;
      scaled = 64'($signed(price)) << FRAC_W;
      if (start || !series_open) begin
         short_ema   = scaled;
         long_ema    = scaled;
         macd_fx     = short_ema - long_ema;
         signal_ema  = macd_fx;
         series_open = 1'b1;
      end else begin
         short_ema  = ema_advance(short_ema, scaled, short_alpha_cfg);
         long_ema   = ema_advance(long_ema, scaled, long_alpha_cfg);
         macd_fx    = short_ema - long_ema;
         signal_ema = ema_advance(signal_ema, macd_fx, signal_alpha_cfg);
      end
      macd_r   = to_thousandths(macd_fx);
      signal_r = to_thousandths(signal_ema);
      hist_r   = macd_r - signal_r;
      res.macd_value      = macd_r[32:0];
      res.signal_value    = signal_r[32:0];
      res.histogram_value = hist_r[33:0];
      return res;
   endfunction

   // Compare each result beat against the oldest prediction
   always @(posedge clock) begin : check_results
      macd_result_type got;
      macd_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.macd_value      = rsp_tdata[32:0];
         got.signal_value    = rsp_tdata[65:33];
         got.histogram_value = rsp_tdata[99:66];
         if (expected_macd_q.size() == 0) begin
            $error("result beat with no prediction pending");
            mismatch_count++;
         end else begin
            want = expected_macd_q.pop_front();
            if (got.macd_value !== want.macd_value) begin
               $error("macd_value: expected %0d, got %0d",
                      $signed(want.macd_value), $signed(got.macd_value));
               mismatch_count++;
            end
            if (got.signal_value !== want.signal_value) begin
               $error("signal_value: expected %0d, got %0d",
                      $signed(want.signal_value), $signed(got.signal_value));
               mismatch_count++;
            end
            if (got.histogram_value !== want.histogram_value) begin
               $error("histogram_value: expected %0d, got %0d",
                      $signed(want.histogram_value), $signed(got.histogram_value));
               mismatch_count++;
            end
         end
      end
   end

   // Drive rsp_tready: random stall bursts, or a long hold when asked
   initial begin : drive_rsp_ready
      int n;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one sample beat, hold until taken, then record its prediction
   task automatic send_sample(input logic [PRICE_W-1:0] price, input logic start);
      @(negedge clock);
      if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(price);
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      expected_macd_q.push_back(macd_predict(price, start));
   endtask

   // Stop offering and wait for every predicted result
   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_macd_q.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [macd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [macd_pkg::ALPHA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         macd_pkg::CSR_SHORT_ALPHA:  short_alpha_cfg  = value;
         macd_pkg::CSR_LONG_ALPHA:   long_alpha_cfg   = value;
         macd_pkg::CSR_SIGNAL_ALPHA: signal_alpha_cfg = value;
         default: ;
      endcase
   endtask

   task automatic set_alphas(input logic [macd_pkg::ALPHA_W-1:0] s,
                             input logic [macd_pkg::ALPHA_W-1:0] l,
                             input logic [macd_pkg::ALPHA_W-1:0] g);
      csr_write(macd_pkg::CSR_SHORT_ALPHA, s);
      csr_write(macd_pkg::CSR_LONG_ALPHA, l);
      csr_write(macd_pkg::CSR_SIGNAL_ALPHA, g);
   endtask

   function automatic logic [macd_pkg::ALPHA_W-1:0] pick_alpha();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return macd_pkg::ALPHA_ONE;
         2:       return ALPHA_TOP;
         3:       return macd_pkg::ALPHA_W'($urandom_range(32'(macd_pkg::ALPHA_ONE) + 1,
                                                           32'(ALPHA_TOP)));
         default: return macd_pkg::ALPHA_W'($urandom_range(1,
                                                           32'(macd_pkg::ALPHA_ONE) - 1));
      endcase
   endfunction

   // Next price: mostly a random walk, sometimes a jump or an extreme
   function automatic logic [PRICE_W-1:0] next_price(input logic [PRICE_W-1:0] prev,
                                                     input bit fresh);
      longint p;
      case ($urandom_range(0, 15))
         0: return PRICE_W'($urandom);
         1: return PRICE_MIN;
         2: return PRICE_MAX;
         3: begin
            p = longint'($signed(prev)) + longint'($signed(PRICE_W'($urandom))) / 8;
         end
         default: begin
            if (fresh)
               p = longint'($urandom_range(0, 400000000)) - 200000000;
            else
               p = longint'($signed(prev)) + longint'($urandom_range(0, 40000)) - 20000;
         end
      endcase
      if (p > longint'($signed(PRICE_MAX)))
         p = longint'($signed(PRICE_MAX));
      if (p < longint'($signed(PRICE_MIN)))
         p = longint'($signed(PRICE_MIN));
      return PRICE_W'(p);
   endfunction

   // Series with a start flag on the first beat, plus a few misplaced or missing flags
   task automatic send_series_mix(input int count);
      int                 sent;
      int                 len;
      int                 k;
      logic [PRICE_W-1:0] price;
      logic               start;
      sent  = 0;
      price = '0;
      while (sent < count) begin
         len = $urandom_range(1, 60);
         for (k = 0; k < len && sent < count; k++) begin
            if (k == 0)
               start = ($urandom_range(0, 9) != 0);
            else
               start = ($urandom_range(0, 39) == 0);
            price = next_price(price, k == 0);
            send_sample(price, start);
            sent++;
         end
      end
   endtask

   // First beat after reset seeds without a flag; price extremes at default coefficients
   task automatic test_seed_and_extremes();
      send_sample(PRICE_W'(1000), 1'b0);
      send_sample(PRICE_MAX, 1'b0);
      send_sample(PRICE_MIN, 1'b0);
      send_sample('0, 1'b0);
      send_sample('1, 1'b0);
      send_sample(PRICE_W'(1), 1'b0);
      send_sample(PRICE_MIN, 1'b1);
      send_sample(PRICE_MAX, 1'b0);
      send_sample(PRICE_W'(-500), 1'b0);
      send_sample(PRICE_W'(-1500), 1'b0);
      wait_results_drained();
   endtask

   // Zero keeps the seed; one and above one follow the input exactly
   task automatic test_alpha_limits();
      set_alphas('0, ALPHA_TOP, macd_pkg::ALPHA_ONE);
      send_sample(PRICE_W'(2000), 1'b1);
      send_sample(PRICE_W'(7000), 1'b0);
      send_sample(PRICE_W'(-3), 1'b0);
      send_sample(PRICE_MAX, 1'b0);
      send_sample(PRICE_MIN, 1'b0);
      wait_results_drained();
      set_alphas(macd_pkg::ALPHA_ONE + 1'b1, macd_pkg::ALPHA_W'(1), '0);
      send_sample(PRICE_MIN, 1'b1);
      send_sample(PRICE_MAX, 1'b0);
      send_sample(PRICE_W'(123456), 1'b0);
      send_sample(PRICE_W'(-7), 1'b0);
      wait_results_drained();
   endtask

   // A write to an unmapped index must leave every coefficient alone
   task automatic test_unmapped_index();
      set_alphas(macd_pkg::SHORT_ALPHA_RST, macd_pkg::LONG_ALPHA_RST,
                 macd_pkg::SIGNAL_ALPHA_RST);
      csr_write(CSR_UNMAPPED, ALPHA_TOP);
      csr_write(CSR_UNMAPPED, '0);
      send_sample(PRICE_W'(5000), 1'b1);
      send_sample(PRICE_W'(9000), 1'b0);
      send_sample(PRICE_W'(-9000), 1'b0);
      wait_results_drained();
   endtask

   // Random series over several coefficient settings
   task automatic test_random_series();
      int phase;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_alphas(macd_pkg::SHORT_ALPHA_RST, macd_pkg::LONG_ALPHA_RST,
                          macd_pkg::SIGNAL_ALPHA_RST);
            1: set_alphas(ALPHA_TOP, '0, macd_pkg::ALPHA_W'(1));
            2: set_alphas('0, macd_pkg::ALPHA_ONE, ALPHA_TOP);
            default: set_alphas(pick_alpha(), pick_alpha(), pick_alpha());
         endcase
         send_series_mix(220);
         wait_results_drained();
      end
   endtask

   // Hold off the result side so the filter fills and stalls its input
   task automatic test_input_backpressure();
      set_alphas(macd_pkg::ALPHA_W'($urandom_range(1, 32'(macd_pkg::ALPHA_ONE))),
                 macd_pkg::ALPHA_W'($urandom_range(1, 32'(macd_pkg::ALPHA_ONE))),
                 macd_pkg::ALPHA_W'($urandom_range(1, 32'(macd_pkg::ALPHA_ONE))));
      rsp_hold_cycles = 300;
      send_series_mix(40);
      wait_results_drained();
   endtask

   // Back-to-back beats with no gaps or stalls
   task automatic test_full_rate();
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      set_alphas(macd_pkg::SHORT_ALPHA_RST, macd_pkg::LONG_ALPHA_RST,
                 macd_pkg::SIGNAL_ALPHA_RST);
      send_series_mix(200);
      wait_results_drained();
   endtask

   initial begin
      short_alpha_cfg  = macd_pkg::SHORT_ALPHA_RST;
      long_alpha_cfg   = macd_pkg::LONG_ALPHA_RST;
      signal_alpha_cfg = macd_pkg::SIGNAL_ALPHA_RST;
      short_ema        = '0;
      long_ema         = '0;
      signal_ema       = '0;
      series_open      = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_seed_and_extremes();
      test_alpha_limits();
      test_unmapped_index();
      test_random_series();
      test_input_backpressure();
      test_full_rate();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_macd_q.size() != 0) begin
         $error("%0d predicted results never arrived", expected_macd_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/macd_pkg.sv
hw/rtl/macd_front.sv
hw/rtl/macd_back.sv
hw/rtl/macd_indicator_filter.sv
tb/tb_top.sv
